### hw/rtl/led_seq_pkg.sv
package led_seq_pkg;

  // command codes carried in the mode field
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_RAW    = 2'd1;
  localparam logic [1:0] MODE_DIGIT  = 2'd2;
  localparam logic [1:0] MODE_BRIGHT = 2'd3;

  localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
  localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
  localparam logic [7:0] CMD_DISP_BASE  = 8'h88;

  // a brightness-only sequence is the tail of the display sequence
  localparam logic [7:0] BRIGHT_BASE = 8'd91;
  localparam logic [7:0] SEQ_SLOTS   = 8'd123;

  localparam logic [3:0] DIGIT_MAX    = 4'd9;
  localparam logic [2:0] DIGIT_POSMAX = 3'd3;

  // byte sources
  localparam logic [1:0] SEL_FIXED  = 2'd0;
  localparam logic [1:0] SEL_ADDR   = 2'd1;
  localparam logic [1:0] SEL_SEGS   = 2'd2;
  localparam logic [1:0] SEL_BRIGHT = 2'd3;

  typedef enum logic [1:0] {
    PART_START,
    PART_BYTE,
    PART_ACK,
    PART_STOP
  } part_t;

  typedef struct packed {
    logic       done;   // slot beyond the sequence
    logic       last;   // final slot of the sequence
    logic       first;  // first slot of a byte
    part_t      ptype;
    logic [1:0] sel;
    logic [1:0] off;    // offset inside an ack or stop
  } slot_dec_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic accepted;
  } res_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7f;
      4'd9: s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/led_seq_if.sv
interface led_seq_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] position;
  logic [7:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface led_seq_out_if (input logic clk);
  logic valid;
  logic ready;
  logic clk_level;
  logic dio_level;
  logic dio_drive;
  logic busy_res;
  logic accepted;

  modport source (output valid, output clk_level, output dio_level, output dio_drive,
                  output busy_res, output accepted, input ready);
  modport sink   (input valid, input clk_level, input dio_level, input dio_drive,
                  input busy_res, input accepted, output ready);
endinterface

### hw/rtl/led_seq_decode.sv
module led_seq_decode (
  input  logic [6:0]             slot,
  input  logic                   kind,
  output led_seq_pkg::slot_dec_t dec
);
  import led_seq_pkg::*;

  logic [7:0] e;

  assign e = kind ? ({1'b0, slot} + BRIGHT_BASE) : {1'b0, slot};

  always_comb begin
    logic [7:0] d;
    d = 8'd0;
    dec = '0;
    dec.ptype = PART_START;
    if (e >= SEQ_SLOTS) begin
      dec.done = 1'b1;
    end else if (e == 8'd0 || e == 8'd32 || e == BRIGHT_BASE) begin
      dec.ptype = PART_START;
    end else if (e <= 8'd24) begin
      dec.ptype = PART_BYTE;
      dec.sel   = SEL_FIXED;
      dec.first = (e == 8'd1);
    end else if (e <= 8'd27) begin
      dec.ptype = PART_ACK;
      d = e - 8'd25;
      dec.off = d[1:0];
    end else if (e <= 8'd31) begin
      dec.ptype = PART_STOP;
      d = e - 8'd28;
      dec.off = d[1:0];
    end else if (e <= 8'd56) begin
      dec.ptype = PART_BYTE;
      dec.sel   = SEL_ADDR;
      dec.first = (e == 8'd33);
    end else if (e <= 8'd59) begin
      dec.ptype = PART_ACK;
      d = e - 8'd57;
      dec.off = d[1:0];
    end else if (e <= 8'd83) begin
      dec.ptype = PART_BYTE;
      dec.sel   = SEL_SEGS;
      dec.first = (e == 8'd60);
    end else if (e <= 8'd86) begin
      dec.ptype = PART_ACK;
      d = e - 8'd84;
      dec.off = d[1:0];
    end else if (e <= 8'd90) begin
      dec.ptype = PART_STOP;
      d = e - 8'd87;
      dec.off = d[1:0];
    end else if (e <= 8'd115) begin
      dec.ptype = PART_BYTE;
      dec.sel   = SEL_BRIGHT;
      dec.first = (e == 8'd92);
    end else if (e <= 8'd118) begin
      dec.ptype = PART_ACK;
      d = e - 8'd116;
      dec.off = d[1:0];
    end else begin
      dec.ptype = PART_STOP;
      d = e - 8'd119;
      dec.off = d[1:0];
      dec.last = (e == SEQ_SLOTS - 8'd1);
    end
  end

endmodule

### hw/rtl/led_seq_core.sv
module led_seq_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        mode,
  input  logic [2:0]        position,
  input  logic [7:0]        value,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_data,
  output led_seq_pkg::res_t res
);
  import led_seq_pkg::*;

  logic [2:0] bright_r;
  logic [6:0] slot_r, slot_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] addr_r, addr_nxt;
  logic [7:0] segs_r, segs_nxt;
  logic       clk_r, clk_nxt;
  logic       dio_r, dio_nxt;
  logic       drive_r, drive_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] phase_r, phase_nxt;

  slot_dec_t dec;

  led_seq_decode u_decode (
    .slot (slot_r),
    .kind (kind_r),
    .dec  (dec)
  );

  always_comb begin
    logic       acc;
    logic [7:0] cur;
    acc       = 1'b0;
    slot_nxt  = slot_r;
    kind_nxt  = kind_r;
    shift_nxt = shift_r;
    addr_nxt  = addr_r;
    segs_nxt  = segs_r;
    clk_nxt   = clk_r;
    dio_nxt   = dio_r;
    drive_nxt = drive_r;
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    cur       = shift_r;

    if (mode == MODE_TICK) begin
      if (busy_r) begin
        if (dec.done) begin
          busy_nxt = 1'b0;
          slot_nxt = '0;
        end else begin
          case (dec.ptype)
            PART_START: begin
              dio_nxt   = 1'b0;
              drive_nxt = 1'b1;
            end
            PART_BYTE: begin
              if (dec.first) begin
                case (dec.sel)
                  SEL_FIXED:  cur = CMD_FIXED_ADDR;
                  SEL_ADDR:   cur = CMD_ADDR_BASE | {5'd0, addr_r};
                  SEL_SEGS:   cur = segs_r;
                  SEL_BRIGHT: cur = CMD_DISP_BASE | {5'd0, bright_r};
                  default:    cur = shift_r;
                endcase
              end
              shift_nxt = cur;
              case (phase_r)
                2'd0: begin
                  clk_nxt   = 1'b0;
                  drive_nxt = 1'b1;
                end
                2'd1: begin
                  dio_nxt   = cur[0];
                  shift_nxt = {1'b0, cur[7:1]};
                end
                default: clk_nxt = 1'b1;
              endcase
              phase_nxt = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
            end
            PART_ACK: begin
              if (dec.off == 2'd0) begin
                drive_nxt = 1'b0;
                clk_nxt   = 1'b0;
              end else if (dec.off == 2'd2) begin
                clk_nxt = 1'b1;
              end
            end
            default: begin
              case (dec.off)
                2'd0: begin
                  clk_nxt   = 1'b0;
                  drive_nxt = 1'b1;
                end
                2'd1: dio_nxt = 1'b0;
                2'd2: clk_nxt = 1'b1;
                default: dio_nxt = 1'b1;
              endcase
            end
          endcase
          if (dec.last) begin
            slot_nxt = '0;
            busy_nxt = 1'b0;
          end else begin
            slot_nxt = slot_r + 7'd1;
          end
        end
      end
    end else if (!busy_r) begin
      case (mode)
        MODE_RAW: begin
          addr_nxt = position;
          segs_nxt = value;
          kind_nxt = 1'b0;
          acc      = 1'b1;
        end
        MODE_DIGIT: begin
          if (position <= DIGIT_POSMAX && value <= {4'd0, DIGIT_MAX}) begin
            addr_nxt = position;
            segs_nxt = digit_seg(value[3:0]);
            kind_nxt = 1'b0;
            acc      = 1'b1;
          end
        end
        default: begin
          kind_nxt = 1'b1;
          acc      = 1'b1;
        end
      endcase
      if (acc) begin
        busy_nxt  = 1'b1;
        slot_nxt  = '0;
        phase_nxt = 2'd0;
      end
    end

    res.clk_level = clk_nxt;
    res.dio_level = drive_nxt & dio_nxt;
    res.dio_drive = drive_nxt;
    res.busy_res  = (mode == MODE_TICK) ? busy_r : busy_nxt;
    res.accepted  = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= 3'd7;
      slot_r   <= '0;
      kind_r   <= 1'b0;
      shift_r  <= '0;
      addr_r   <= '0;
      segs_r   <= '0;
      clk_r    <= 1'b1;
      dio_r    <= 1'b1;
      drive_r  <= 1'b1;
      busy_r   <= 1'b0;
      phase_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        bright_r <= cfg_data;
      end
      if (step) begin
        slot_r  <= slot_nxt;
        kind_r  <= kind_nxt;
        shift_r <= shift_nxt;
        addr_r  <= addr_nxt;
        segs_r  <= segs_nxt;
        clk_r   <= clk_nxt;
        dio_r   <= dio_nxt;
        drive_r <= drive_nxt;
        busy_r  <= busy_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (slot_r == 7'd0 && phase_r == 2'd0))
    else $error("idle sequencer holds a nonzero slot or bit phase");

  a_release_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !drive_r |-> busy_r)
    else $error("data wire released outside a sequence");

  a_bright_short: assert property (@(posedge clk) disable iff (!rst_n)
    kind_r |-> slot_r < 7'd32)
    else $error("brightness sequence ran past its frame");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && mode == MODE_TICK && busy_r && dec.last) |=> (!busy_r && clk_r && dio_r))
    else $error("final stop slot did not return to idle wires");

endmodule

### hw/rtl/led_display_two_wire_sequencer.sv
// Two-wire LED display sequencer. A command transaction (raw segments, decimal
// digit or brightness only) is taken only while no sequence runs; each tick
// transaction afterwards advances the clock and data wires by one slot and
// returns their levels. A display write lasts 123 ticks, a brightness write 32.
// Every input transaction yields exactly one result in the next cycle through the
// output register, and a new transaction is accepted every cycle as long as the
// output register is empty or being drained. Brightness is written on cfg_we
// and is sampled when the brightness byte starts shifting.
module led_display_two_wire_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  led_seq_in_if.sink  in_ch,
  led_seq_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data
);
  import led_seq_pkg::*;

  logic out_valid_r;
  res_t out_r;
  res_t res;
  logic step;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  led_seq_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .mode     (in_ch.mode),
    .position (in_ch.position),
    .value    (in_ch.value),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.clk_level = out_r.clk_level;
  assign out_ch.dio_level = out_r.dio_level;
  assign out_ch.dio_drive = out_r.dio_drive;
  assign out_ch.busy_res  = out_r.busy_res;
  assign out_ch.accepted  = out_r.accepted;

endmodule
